// ----- design/pib_pkg.sv -----
// Shared types, constants and helpers for the point-in-box collision table.
`default_nettype none

package pib_pkg;

  // Table depth, one chain cell per entry.
  localparam int MAX_BOXES = 16;
  localparam int IDX_W     = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CNT_W     = $clog2(MAX_BOXES + 1);

  // Fixed result field widths.
  localparam int HIT_IDX_W = 4;
  localparam int COUNT_W   = 5;

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [HIT_IDX_W-1:0] hit_idx_t;
  typedef logic [COUNT_W-1:0]   count_t;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  // One stored box.
  typedef struct packed {
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic [14:0]        sx;
    logic [14:0]        sy;
  } box_t;

  // Item traveling down the cell chain.
  typedef struct packed {
    logic  valid;
    cmd_t  cmd;
    box_t  box;     // load: box to store; query: point in cx/cy
    idx_t  tgt;     // load: destination cell
    logic  full;    // load dropped
    cnt_t  count;   // entries held after this item
    logic  hit;
    idx_t  hit_idx;
  } token_t;

  // Low bits of the index, zero-extended when the index is narrow.
  function automatic hit_idx_t to_hit_idx(input idx_t idx);
    logic [IDX_W+HIT_IDX_W-1:0] ext;
    ext = {{HIT_IDX_W{1'b0}}, idx};
    return ext[HIT_IDX_W-1:0];
  endfunction

  function automatic count_t to_count(input cnt_t cnt);
    logic [CNT_W+COUNT_W-1:0] ext;
    ext = {{COUNT_W{1'b0}}, cnt};
    return ext[COUNT_W-1:0];
  endfunction

  // -size <= 2*(point - center) < size
  function automatic logic axis_inside(input logic signed [15:0] p,
                                       input logic signed [15:0] c,
                                       input logic [14:0] s);
    logic signed [16:0] d;
    logic signed [17:0] d2;
    logic signed [17:0] se;
    d  = {p[15], p} - {c[15], c};
    d2 = {d, 1'b0};
    se = {3'b000, s};
    return (-se <= d2) && (d2 < se);
  endfunction

endpackage

`default_nettype wire

// ----- design/pib_cell.sv -----
// One chain cell: holds one box, writes it on its load, tests passing queries.
`default_nettype none

module pib_cell (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire pib_pkg::idx_t   cell_idx,
  input  wire pib_pkg::token_t tok_in,
  output pib_pkg::token_t      tok_out
);

  pib_pkg::box_t   box_r;
  pib_pkg::token_t tok_r;
  pib_pkg::token_t tok_nxt;
  logic            wr_en;
  logic            in_use;
  logic            contained;

  assign wr_en  = en && tok_in.valid && (tok_in.cmd == pib_pkg::CMD_LOAD) &&
                  !tok_in.full && (tok_in.tgt == cell_idx);
  assign in_use = pib_pkg::cnt_t'(cell_idx) < tok_in.count;
  assign contained = pib_pkg::axis_inside(tok_in.box.cx, box_r.cx, box_r.sx) &&
                     pib_pkg::axis_inside(tok_in.box.cy, box_r.cy, box_r.sy);

  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.cmd == pib_pkg::CMD_QUERY && !tok_in.hit && in_use && contained) begin
      tok_nxt.hit     = 1'b1;
      tok_nxt.hit_idx = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      box_r <= tok_in.box;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else if (en) begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

`default_nettype wire

// ----- design/point_in_box_collision_table_unit.sv -----
// Top level of the point-in-box collision table: entry logic, cell chain, output stage.
//
// Usage:
//  - Input channel (in_valid/in_ready): one command per transfer. CLEAR empties
//    the table, LOAD appends a box (dropped and flagged with out_table_full
//    when all MAX_BOXES entries are taken), QUERY tests the point in
//    in_pos_x/in_pos_y against the stored boxes, lowest index first.
//  - Output channel (out_valid/out_ready): exactly one result per command,
//    in command order: hit, hit index, count after the command, full flag.
//  - The entry count is updated when a command is taken; every command then
//    walks a chain of MAX_BOXES cells, one cell per cycle unless stalled. Cell k
//    holds box k and is written by its load, or tested by a query, as the item
//    passes. Items stay in order, so a query sees exactly the loads ahead of it.
//  - Throughput: one command per cycle unless stalled; the chain advances as one unit.
//  - Stall: when out_valid is high and out_ready low the whole chain holds
//    and in_ready drops; nothing is lost or repeated.
//  - Reset (rst_n low, synchronous): count cleared, chain and output emptied.
//    Box storage is not cleared; entries beyond the count are never matched.
`default_nettype none

module point_in_box_collision_table_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [15:0] in_pos_x,
  input  wire logic [15:0] in_pos_y,
  input  wire logic [14:0] in_size_x,
  input  wire logic [14:0] in_size_y,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_hit,
  output logic [3:0]       out_hit_index,
  output logic [4:0]       out_stored_count,
  output logic             out_table_full
);

  // Chain advance: output register empty or being drained.
  logic            adv;
  logic            in_xfer;
  pib_pkg::cnt_t   count_r;
  pib_pkg::cnt_t   count_nxt;
  pib_pkg::token_t entry_tok;
  pib_pkg::token_t tok [0:pib_pkg::MAX_BOXES];
  pib_pkg::token_t out_r;
  logic            out_valid_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;
  assign in_xfer  = in_valid && in_ready;

  // Entry: resolve the count now so loads know their cell and queries their limit.
  always_comb begin
    entry_tok          = '0;
    entry_tok.valid    = in_valid;
    entry_tok.cmd      = pib_pkg::cmd_t'(in_cmd);
    entry_tok.box.cx   = in_pos_x;
    entry_tok.box.cy   = in_pos_y;
    entry_tok.box.sx   = in_size_x;
    entry_tok.box.sy   = in_size_y;
    count_nxt          = count_r;
    unique case (pib_pkg::cmd_t'(in_cmd))
      pib_pkg::CMD_CLEAR: begin
        count_nxt = '0;
      end
      pib_pkg::CMD_LOAD: begin
        if (count_r < pib_pkg::cnt_t'(pib_pkg::MAX_BOXES)) begin
          entry_tok.tgt = pib_pkg::idx_t'(count_r);
          count_nxt     = count_r + pib_pkg::cnt_t'(1);
        end else begin
          entry_tok.full = 1'b1;
        end
      end
      pib_pkg::CMD_QUERY: begin
        count_nxt = count_r;
      end
      pib_pkg::CMD_NOP: begin
        count_nxt = count_r;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
    entry_tok.count = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (in_xfer) begin
      count_r <= count_nxt;
    end
  end

  assign tok[0] = entry_tok;

  // Cell chain.
  for (genvar k = 0; k < pib_pkg::MAX_BOXES; k++) begin : g_cell
    pib_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .cell_idx (pib_pkg::idx_t'(k)),
      .tok_in   (tok[k]),
      .tok_out  (tok[k+1])
    );
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= tok[pib_pkg::MAX_BOXES].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= tok[pib_pkg::MAX_BOXES];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_r.hit;
  assign out_hit_index    = pib_pkg::to_hit_idx(out_r.hit_idx);
  assign out_stored_count = pib_pkg::to_count(out_r.count);
  assign out_table_full   = out_r.full;

  // Count never exceeds the table depth.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= pib_pkg::cnt_t'(pib_pkg::MAX_BOXES))
    else $error("entry count beyond table depth");

  // A clear empties the table at once.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (in_cmd == pib_pkg::CMD_CLEAR) |=> count_r == '0)
    else $error("clear did not reset count");

  // A hit only names a stored entry.
  a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.hit |-> pib_pkg::cnt_t'(out_r.hit_idx) < out_r.count)
    else $error("hit on entry beyond count");

  // A dropped load is reported only with a full table.
  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.full |->
      (out_r.count == pib_pkg::cnt_t'(pib_pkg::MAX_BOXES)) && !out_r.hit)
    else $error("full flag with room left or with a hit");

  // Stall holds the result register.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_r))
    else $error("result changed under stall");

endmodule

`default_nettype wire

// ----- sim/point_in_box_collision_table_unit_tb.sv -----
// Testbench for point_in_box_collision_table_unit: box table loads, clears and point queries.
module point_in_box_collision_table_unit_tb;

  // Run sizing. The chain is MAX_BOXES + 1 deep; tail covers that with margin.
  localparam int ITEM_TARGET = 1650;
  localparam int TAIL_CYCLES = 40;
  localparam int HOLD_CYCLES = 150;   // long receiver hold-off in the pressure test
  localparam int QUIET_LIMIT = 2000;  // cycles with no transfer before giving up

  // One result as the block reports it, in port order.
  typedef struct packed {
    logic       hit;
    logic [3:0] idx;
    logic [4:0] count;
    logic       full;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_cmd = pib_pkg::CMD_NOP;
  logic [15:0] in_pos_x = '0;
  logic [15:0] in_pos_y = '0;
  logic [14:0] in_size_x = '0;
  logic [14:0] in_size_y = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_hit;
  logic [3:0]  out_hit_index;
  logic [4:0]  out_stored_count;
  logic        out_table_full;

  // Predicted table contents and occupancy, advanced at each input transfer.
  pib_pkg::box_t shelf [pib_pkg::MAX_BOXES];
  int            shelf_count = 0;
  verdict_t      expected_q [$];

  int          items_sent = 0;
  int          mismatches = 0;

  // Handshake between the pressure test and the receiver process.
  bit          hold_req = 1'b0;
  bit          hold_active = 1'b0;

  point_in_box_collision_table_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_size_x        (in_size_x),
    .in_size_y        (in_size_y),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_hit          (out_hit),
    .out_hit_index    (out_hit_index),
    .out_stored_count (out_stored_count),
    .out_table_full   (out_table_full)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Half-open interval test done in plain int math: -s <= 2*(p - c) < s.
  function automatic bit within_span(input logic [15:0] p, input logic [15:0] c,
                                     input logic [14:0] s);
    int twice_delta;
    int span;
    twice_delta = 2 * ($signed(p) - $signed(c));
    span = int'(s);
    return (twice_delta >= -span) && (twice_delta < span);
  endfunction

  // Applies one command to the predicted table and returns the result it causes.
  function automatic verdict_t apply_command(input pib_pkg::cmd_t cmd,
                                             input logic [15:0] px,
                                             input logic [15:0] py, input logic [14:0] sx,
                                             input logic [14:0] sy);
    verdict_t v;
    int       k;
    v = '0;
    case (cmd)
      pib_pkg::CMD_CLEAR: begin
        // Only the count goes; stale entries are overwritten before any query sees them.
        shelf_count = 0;
      end
      pib_pkg::CMD_LOAD: begin
        if (shelf_count < pib_pkg::MAX_BOXES) begin
          shelf[shelf_count] = '{cx: px, cy: py, sx: sx, sy: sy};
          shelf_count++;
        end else begin
          v.full = 1'b1;
        end
      end
      pib_pkg::CMD_QUERY: begin
        // Lowest index wins.
        for (k = 0; k < shelf_count; k++) begin
          if (!v.hit && within_span(px, shelf[k].cx, shelf[k].sx)
                     && within_span(py, shelf[k].cy, shelf[k].sy)) begin
            v.hit = 1'b1;
            v.idx = 4'(k);
          end
        end
      end
      default: ;  // unused command: count only
    endcase
    v.count = 5'(shelf_count);
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Sender gap: mostly back to back, some short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Half the time a clustered coordinate so boxes overlap, else full range.
  function automatic logic [15:0] rand_coord();
    if ($urandom_range(0, 1)) return 16'($urandom);
    return 16'($urandom_range(0, 1023) - 512);
  endfunction

  function automatic logic [14:0] rand_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 65) return 15'($urandom_range(1, 600));
    return 15'($urandom);
  endfunction

  // Coordinate near a box edge on one axis: exact edges, one past, or somewhere close.
  function automatic logic [15:0] probe_coord(input logic [15:0] c, input logic [14:0] s);
    int lo_in;
    int hi_in;
    int off;
    lo_in = -int'(s >> 1);
    hi_in = (s == 0) ? 0 : int'((s - 1) >> 1);
    case ($urandom_range(0, 5))
      0:       off = lo_in;
      1:       off = lo_in - 1;
      2:       off = hi_in;
      3:       off = hi_in + 1;
      default: off = $urandom_range(0, hi_in - lo_in + 8) + lo_in - 4;
    endcase
    return 16'($signed(c) + off);
  endfunction

  // Offers one item, waits for its transfer, records the prediction, then idles
  // for the given gap. With gap 0 valid stays high for the next item.
  task automatic send_item(input pib_pkg::cmd_t cmd, input logic [15:0] px,
                           input logic [15:0] py,
                           input logic [14:0] sx, input logic [14:0] sy, input int gap);
    in_valid  <= 1'b1;
    in_cmd    <= cmd;
    in_pos_x  <= px;
    in_pos_y  <= py;
    in_size_x <= sx;
    in_size_y <= sy;
    do @(posedge clk); while (!in_ready);
    expected_q.insert(expected_q.size(), apply_command(cmd, px, py, sx, sy));
    items_sent++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drops valid and waits until every predicted result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Edges of the containment test, zero sizes, lowest-index priority,
  // extreme coordinates, unused command and clear.
  task automatic test_basic_commands();
    send_item(pib_pkg::CMD_QUERY, 0, 0, 0, 0, pick_gap());              // empty table
    send_item(pib_pkg::CMD_NOP, 16'hFFFF, 16'hFFFF, 15'h7FFF, 15'h7FFF, 0);
    send_item(pib_pkg::CMD_LOAD, 100, -100, 10, 11, pick_gap());        // idx 0
    send_item(pib_pkg::CMD_LOAD, 100, -100, 0, 500, 0);                 // idx 1, zero width
    send_item(pib_pkg::CMD_LOAD, 0, 0, 15'h7FFF, 15'h7FFF, pick_gap()); // idx 2, widest
    send_item(pib_pkg::CMD_QUERY, 95, -105, 15'h7FFF, 0, 0);            // lower edges: idx 0
    send_item(pib_pkg::CMD_QUERY, 94, -100, 0, 0, pick_gap());          // just below x edge
    send_item(pib_pkg::CMD_QUERY, 104, -95, 0, 0, 0);                   // upper edges inside
    send_item(pib_pkg::CMD_QUERY, 105, -100, 0, 0, 0);                  // x upper edge out
    send_item(pib_pkg::CMD_QUERY, 100, -106, 0, 0, pick_gap());         // just below y edge
    send_item(pib_pkg::CMD_QUERY, -32768, 32767, 0, 0, 0);              // far corner, no hit
    send_item(pib_pkg::CMD_QUERY, 16383, -16383, 0, 0, 0);              // inside widest box
    send_item(pib_pkg::CMD_QUERY, -16384, 0, 0, 0, pick_gap());         // outside widest
    send_item(pib_pkg::CMD_LOAD, -32768, 32767, 15'h7FFF, 0, 0);        // idx 3, zero height
    send_item(pib_pkg::CMD_QUERY, -32768, 32767, 0, 0, 0);              // zero height: miss
    send_item(pib_pkg::CMD_NOP, 0, 0, 0, 0, pick_gap());
    send_item(pib_pkg::CMD_CLEAR, 16'h8000, 16'h7FFF, 0, 0, 0);
    send_item(pib_pkg::CMD_QUERY, 100, -100, 0, 0, pick_gap());         // stale entries unseen
    drain_results();
  endtask

  // Fill every entry, overflow once, hit the last entry, then reuse after clear.
  task automatic test_table_full();
    int k;
    for (k = 0; k < pib_pkg::MAX_BOXES - 1; k++)
      send_item(pib_pkg::CMD_LOAD, 16'(-20000 + k * 500), 20000, 4, 4, pick_gap());
    send_item(pib_pkg::CMD_LOAD, 32767, -32768, 1, 1, 0);               // last entry
    send_item(pib_pkg::CMD_LOAD, 0, 0, 15'h7FFF, 15'h7FFF, pick_gap()); // dropped, full
    send_item(pib_pkg::CMD_QUERY, 32767, -32768, 0, 0, 0);              // highest index
    send_item(pib_pkg::CMD_QUERY, 32766, -32768, 0, 0, 0);              // just outside it
    send_item(pib_pkg::CMD_QUERY, 0, 0, 0, 0, pick_gap());              // dropped box absent
    send_item(pib_pkg::CMD_CLEAR, 0, 0, 0, 0, 0);
    send_item(pib_pkg::CMD_LOAD, 0, 0, 8, 8, 0);
    send_item(pib_pkg::CMD_QUERY, 3, -4, 0, 0, pick_gap());
    drain_results();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering,
  // so the chain fills and in_ready drops.
  task automatic test_output_backpressure();
    int n;
    hold_req = 1'b1;
    while (!hold_active) @(posedge clk);
    for (n = 0; n < 40; n++) begin
      if (n % 3 == 2)
        send_item(pib_pkg::CMD_QUERY, rand_coord(), rand_coord(), rand_span(),
                  rand_span(), 0);
      else
        send_item(pib_pkg::CMD_LOAD, rand_coord(), rand_coord(), rand_span(),
                  rand_span(), 0);
    end
    drain_results();
  endtask

  // Scenes: usually a clear, a run of loads (sometimes past full), then queries
  // that mostly probe the edges of stored boxes, plus some noise.
  task automatic test_random_scenes();
    int          r;
    int          n;
    int          n_loads;
    int          n_queries;
    int          k;
    bit          steady;
    logic [15:0] px;
    logic [15:0] py;
    while (items_sent < ITEM_TARGET) begin
      steady = ($urandom_range(0, 4) == 0);  // some scenes with no sender gaps
      if ($urandom_range(0, 99) < 85)
        send_item(pib_pkg::CMD_CLEAR, rand_coord(), rand_coord(), rand_span(), rand_span(),
                  steady ? 0 : pick_gap());
      n_loads = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 8);
      for (n = 0; n < n_loads; n++)
        send_item(pib_pkg::CMD_LOAD, rand_coord(), rand_coord(), rand_span(), rand_span(),
                  steady ? 0 : pick_gap());
      n_queries = $urandom_range(4, 16);
      for (n = 0; n < n_queries; n++) begin
        r = $urandom_range(0, 99);
        if (r < 72 && shelf_count > 0) begin
          k  = $urandom_range(0, shelf_count - 1);
          px = probe_coord(shelf[k].cx, shelf[k].sx);
          py = probe_coord(shelf[k].cy, shelf[k].sy);
          send_item(pib_pkg::CMD_QUERY, px, py, 15'($urandom), 15'($urandom),
                    steady ? 0 : pick_gap());
        end else if (r < 92) begin
          send_item(pib_pkg::CMD_QUERY, rand_coord(), rand_coord(), 15'($urandom),
                    15'($urandom), steady ? 0 : pick_gap());
        end else begin
          // any command, random fields: stray clears, loads, unused code
          send_item(pib_pkg::cmd_t'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                    15'($urandom), 15'($urandom), steady ? 0 : pick_gap());
        end
      end
      // Now and then the sender waits for every result before going on.
      if ($urandom_range(0, 9) == 0)
        drain_results();
    end
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random ready, with the long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    int r;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active = 1'b0;
        hold_req = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_ready <= 1'b1;
          @(posedge clk);
        end else if (r < 70) begin
          out_ready <= 1'b1;                       // steady stretch
          repeat ($urandom_range(20, 60)) @(posedge clk);
        end else if (r < 95) begin
          out_ready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else begin
          out_ready <= 1'b0;
          repeat ($urandom_range(10, 40)) @(posedge clk);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: each output transfer against the oldest prediction
  // ---------------------------------------------------------------------------
  initial begin
    verdict_t want;
    verdict_t got;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got = {out_hit, out_hit_index, out_stored_count, out_table_full};
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: hit=%0b idx=%0d count=%0d full=%0b",
                     got.hit, got.idx, got.count, got.full);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected hit=%0b idx=%0d count=%0d full=%0b,",
                       want.hit, want.idx, want.count, want.full,
                       " got hit=%0b idx=%0d count=%0d full=%0b",
                       got.hit, got.idx, got.count, got.full);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: ends the run after too many cycles with no transfer on either side
  // ---------------------------------------------------------------------------
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_basic_commands();
    test_table_full();
    test_output_backpressure();
    test_random_scenes();

    // Any prediction still waiting after the tail is a result that never arrived.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_q.size() != 0) begin
      $display("%0d results never arrived", expected_q.size());
      mismatches += expected_q.size();
    end

    if (mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
